@@ rtl/core/mcstb_pkg.sv @@
// Shared constants and types of the soft timer bank: channel count, counter
// width, derived index widths and operation codes. No dependencies.
package mcstb_pkg;

    localparam int NUM_CHANNELS  = 16;
    localparam int COUNT_WIDTH   = 32;

    // Index width into the per-channel stores
    localparam int IDX_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    // Channels reachable through the 4-bit channel field
    localparam int SCAN_CHANNELS = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
    localparam int SCAN_W        = IDX_W + 1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [NUM_CHANNELS-1:0] chan_vec_t;

    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_ENABLE   = 3'd1;
    localparam logic [2:0] OP_DISABLE  = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_SERVICE  = 3'd4;

endpackage

@@ rtl/core/mcstb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while read enable is low. No dependencies.
module mcstb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/multi_channel_soft_timer_bank.sv @@
// Top level of the soft timer bank: sequencer, channel flags and the scan
// over the count and reload memories. Uses mcstb_pkg and mcstb_ram.
//
//  Channel  | Direction | Handshake          | Word contents
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_valid / s_ready  | op, channel, period, autoreload, async, notify
//  m_       | out       | m_valid / m_ready  | expired_channel, fired, last
//
// Register, disable, spare ops and service with nothing pending go from idle
// straight to the close; enable passes through ST_ENLOAD (one reload memory
// read). Tick, and service with pending set, scan with one count/reload
// memory read per channel, registered ahead of the update and write back.
// One word is handled at a time; s_ready is high only while idle. A stalled
// m_ channel holds the scan when a second expiry needs the output register,
// and holds the close of every word. Reset is synchronous and needs no clearing pass.
module multi_channel_soft_timer_bank (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [3:0]  s_channel,
    input  logic [31:0] s_period,
    input  logic        s_autoreload,
    input  logic        s_async_mode,
    input  logic        s_notify,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_expired_channel,
    output logic        m_fired,
    output logic        m_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ENLOAD = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [2:0]                  op_reg;
    mcstb_pkg::idx_t             ch_reg;
    logic                        arl_reg, asy_reg, ntf_reg;

    mcstb_pkg::chan_vec_t        present_reg, running_reg, periodic_reg;
    mcstb_pkg::chan_vec_t        async_reg, notify_reg, cnt_valid_reg;
    logic                        pending_reg;

    logic [mcstb_pkg::SCAN_W-1:0] scan_idx_reg;
    logic                        proc_valid_reg;
    mcstb_pkg::idx_t             proc_idx_reg;
    logic                        pend_valid_reg;
    mcstb_pkg::idx_t             pend_ch_reg;

    logic                        m_valid_reg, m_fired_reg, m_last_reg;
    logic [3:0]                  m_ch_reg;

    // Memory ports
    logic                        cnt_we, cnt_re, rld_we, rld_re;
    mcstb_pkg::idx_t             cnt_waddr, rld_raddr, rld_waddr;
    mcstb_pkg::count_t           cnt_wdata, cnt_rdata, rld_rdata;

    logic                        accept, out_free, addr_ok, scan_more, scan_adv;
    mcstb_pkg::idx_t             s_idx, scan_addr;

    // Scan datapath
    logic                        is_tick, p_pres, p_run, p_per, p_asy, p_ntf;
    logic                        p_counts, p_fire, p_reload, p_emit, p_need_out, p_do;
    mcstb_pkg::count_t           p_cnt, p_newc;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign addr_ok   = (32'(s_channel) < mcstb_pkg::NUM_CHANNELS);
    assign s_idx     = mcstb_pkg::IDX_W'(s_channel);
    assign scan_addr = scan_idx_reg[mcstb_pkg::IDX_W-1:0];
    assign scan_more = (scan_idx_reg < mcstb_pkg::SCAN_W'(mcstb_pkg::SCAN_CHANNELS));

    // Evaluate the channel whose entries were last read from the memories
    assign is_tick    = (op_reg == mcstb_pkg::OP_TICK);
    assign p_pres     = present_reg[proc_idx_reg];
    assign p_run      = running_reg[proc_idx_reg];
    assign p_per      = periodic_reg[proc_idx_reg];
    assign p_asy      = async_reg[proc_idx_reg];
    assign p_ntf      = notify_reg[proc_idx_reg];
    assign p_cnt      = cnt_valid_reg[proc_idx_reg] ? cnt_rdata : '0;
    assign p_counts   = p_pres && p_run && (is_tick ? p_asy : !p_asy);
    assign p_fire     = p_counts && (p_cnt <= mcstb_pkg::COUNT_WIDTH'(1));
    assign p_reload   = is_tick ? (p_per && p_ntf) : p_per;
    assign p_newc     = !p_fire ? (p_cnt - mcstb_pkg::COUNT_WIDTH'(1))
                                : (p_reload ? rld_rdata : '0);
    assign p_emit     = p_fire && p_ntf;
    assign p_need_out = p_emit && pend_valid_reg;
    assign scan_adv   = (state_reg == ST_SCAN)
                        && (!proc_valid_reg || !p_need_out || out_free);
    assign p_do       = scan_adv && proc_valid_reg;

    // Route memory ports
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = proc_idx_reg;
        cnt_wdata = p_newc;
        cnt_re    = scan_adv && scan_more;
        rld_we    = accept && (s_op == mcstb_pkg::OP_REGISTER) && addr_ok;
        rld_waddr = s_idx;
        rld_re    = cnt_re;
        rld_raddr = scan_addr;
        if (state_reg == ST_ENLOAD) begin
            cnt_we    = 1'b1;
            cnt_waddr = ch_reg;
            cnt_wdata = rld_rdata;
        end else if (p_do && p_counts) begin
            cnt_we = 1'b1;
        end
        if (accept && (s_op == mcstb_pkg::OP_ENABLE)) begin
            rld_re    = 1'b1;
            rld_raddr = s_idx;
        end
    end

    mcstb_ram #(.WIDTH(mcstb_pkg::COUNT_WIDTH), .DEPTH(mcstb_pkg::NUM_CHANNELS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (scan_addr),
        .rdata (cnt_rdata)
    );

    mcstb_ram #(.WIDTH(mcstb_pkg::COUNT_WIDTH), .DEPTH(mcstb_pkg::NUM_CHANNELS)) u_rld_ram (
        .aclk  (aclk),
        .we    (rld_we),
        .waddr (rld_waddr),
        .wdata (mcstb_pkg::COUNT_WIDTH'(s_period)),
        .re    (rld_re),
        .raddr (rld_raddr),
        .rdata (rld_rdata)
    );

    // Sequence one word
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == mcstb_pkg::OP_ENABLE && addr_ok && present_reg[s_idx]) begin
                        state_next = ST_ENLOAD;
                    end else if (s_op == mcstb_pkg::OP_TICK
                                 || (s_op == mcstb_pkg::OP_SERVICE && pending_reg)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ENLOAD: state_next = ST_DONE;
            ST_SCAN: begin
                if (!scan_more && !proc_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the command of the word in work
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_op;
            ch_reg  <= s_idx;
            arl_reg <= s_autoreload;
            asy_reg <= s_async_mode;
            ntf_reg <= s_notify;
        end
        if (scan_adv) begin
            proc_idx_reg <= scan_addr;
        end
        if (p_do && p_emit) begin
            pend_ch_reg <= proc_idx_reg;
        end
    end

    // Control state, channel flags and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            present_reg    <= '0;
            running_reg    <= '0;
            periodic_reg   <= '0;
            async_reg      <= '0;
            notify_reg     <= '0;
            cnt_valid_reg  <= '0;
            pending_reg    <= 1'b0;
            scan_idx_reg   <= '0;
            proc_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_fired_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
            m_ch_reg       <= '0;
        end else begin
            state_reg <= state_next;

            // Drain the output register
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Register, disable, start of a scan
            if (accept) begin
                scan_idx_reg   <= '0;
                proc_valid_reg <= 1'b0;
                pend_valid_reg <= 1'b0;
                if (s_op == mcstb_pkg::OP_REGISTER && addr_ok) begin
                    present_reg[s_idx] <= 1'b1;
                end
                if (s_op == mcstb_pkg::OP_DISABLE && addr_ok) begin
                    running_reg[s_idx]   <= 1'b0;
                    periodic_reg[s_idx]  <= 1'b0;
                    cnt_valid_reg[s_idx] <= 1'b0;
                end
            end

            // Enable: count loaded from the reload memory this cycle
            if (state_reg == ST_ENLOAD) begin
                running_reg[ch_reg]   <= 1'b1;
                cnt_valid_reg[ch_reg] <= 1'b1;
                periodic_reg[ch_reg]  <= arl_reg;
                async_reg[ch_reg]     <= asy_reg;
                notify_reg[ch_reg]    <= ntf_reg;
            end

            // Advance the scan pipeline
            if (scan_adv) begin
                proc_valid_reg <= scan_more;
                if (scan_more) begin
                    scan_idx_reg <= scan_idx_reg + mcstb_pkg::SCAN_W'(1);
                end
            end

            // Update one channel
            if (p_do) begin
                if (is_tick && p_pres && !p_asy) begin
                    pending_reg <= 1'b1;
                end
                if (p_counts) begin
                    cnt_valid_reg[proc_idx_reg] <= 1'b1;
                end
                if (p_fire && !p_reload) begin
                    running_reg[proc_idx_reg] <= 1'b0;
                end
                if (p_emit) begin
                    pend_valid_reg <= 1'b1;
                    if (pend_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        m_fired_reg <= 1'b1;
                        m_last_reg  <= 1'b0;
                        m_ch_reg    <= 4'(pend_ch_reg);
                    end
                end
            end

            // Close the word: last expiry or a plain acknowledgement
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg    <= 1'b1;
                m_fired_reg    <= pend_valid_reg;
                m_last_reg     <= 1'b1;
                m_ch_reg       <= pend_valid_reg ? 4'(pend_ch_reg) : 4'd0;
                pend_valid_reg <= 1'b0;
                if (op_reg == mcstb_pkg::OP_SERVICE) begin
                    pending_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_fired           = m_fired_reg;
    assign m_last            = m_last_reg;
    assign m_expired_channel = m_ch_reg;

    // A channel never runs without being present
    a_run_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg & ~present_reg) == '0)
        else $error("running channel not present");

    // A running channel always has a written count
    a_run_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg & ~cnt_valid_reg) == '0)
        else $error("running channel without count");

    // Scan pipeline and held expiry only exist during a counting word
    a_scan_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_valid_reg || pend_valid_reg) |->
            (state_reg == ST_SCAN || state_reg == ST_DONE))
        else $error("scan state outside a scan");

    // Closing a word always leaves a final result in the output register
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
            (state_reg == ST_IDLE && m_valid_reg && m_last_reg))
        else $error("word closed without final result");

endmodule
